// File: rtl/prf_pkg.sv
// Shared constants and types for the Pollard rho factoriser.
package prf_pkg;
    localparam int unsigned BASE_ROUND_LOG  = 18;
    localparam int unsigned MIN_ROUNDS      = 3;
    localparam int unsigned MIN_TOTAL_STEPS = 1000;

    localparam logic [1:0] STATUS_FOUND   = 2'd0;
    localparam logic [1:0] STATUS_NONE    = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    localparam logic [0:0] REG_RANDOM_SEED = 1'd0;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DRAW_INC,
        OP_DRAW_START,
        OP_MUL_START,
        OP_MUL_STEP,
        OP_MUL_DONE,
        OP_GCD_START,
        OP_GCD_STEP,
        OP_ANCHOR,
        OP_DIV_START,
        OP_DIV_STEP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic gcd_done;
        logic div_done;
        logic rem_done;
        logic gcd_is_one;
        logic gcd_found;
    } dp_status_t;
endpackage

// File: rtl/pollard_rho_factorizer_64.sv
// Pollard rho factoriser with Brent-style anchor, top level.
// Throughput: one request at a time, the next taken while a result waits in the output register.
// A rho step runs the shift-and-add multiply, the bit-serial gcd (one Euclid step after another)
// and the set-up and test states. An input below 2 goes straight to the output state with
// status invalid; the final divide is bit-serial, through the shared remainder unit.
// Reset: asynchronous, active low; the random seed returns to 1, no clearing pass.
module pollard_rho_factorizer_64 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [62:0] composite,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [62:0] smaller_factor,
    output logic [62:0] larger_factor,
    output logic [1:0]  status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import prf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t dp_st;
    logic       busy, done, seed_we, in_fire;
    logic [1:0] kind;
    logic [62:0] small_v, large_v, comp_reg;
    logic [63:0] seed_v;

    assign pready   = 1'b1;
    assign seed_we  = psel && penable && pwrite && (paddr[3:3] == REG_RANDOM_SEED);
    assign prdata   = (paddr[3:3] == REG_RANDOM_SEED) ? seed_v : 64'd0;
    assign in_ready = !busy;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk)
        if (in_fire) comp_reg <= composite;

    prf_control u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_small(composite < 63'd2),
        .status(dp_st), .out_free(!out_valid || out_ready), .cmd(cmd), .busy(busy),
        .done(done), .result_kind(kind)
    );

    prf_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .composite(composite),
        .seed_we(seed_we), .seed_value(pwdata), .status(dp_st),
        .small_out(small_v), .large_out(large_v), .seed_out(seed_v)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (done)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            status <= kind;
            unique case (kind)
                STATUS_FOUND:   begin smaller_factor <= small_v; larger_factor <= large_v; end
                STATUS_NONE:    begin smaller_factor <= 63'd1; larger_factor <= comp_reg; end
                default:        begin smaller_factor <= 63'd0; larger_factor <= comp_reg; end
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready) else $error("accepted while busy");
    a_done_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> out_valid) else $error("result lost");
    a_found_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_FOUND) |-> (smaller_factor <= larger_factor))
        else $error("factors out of order");
endmodule

// File: rtl/prf_datapath.sv
// Datapath: random source, modular square-add, gcd and final divide.
module prf_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  prf_pkg::dp_cmd_t    cmd,
    input  logic [62:0]         composite,
    input  logic                seed_we,
    input  logic [63:0]         seed_value,
    output prf_pkg::dp_status_t status,
    output logic [62:0]         small_out,
    output logic [62:0]         large_out,
    output logic [63:0]         seed_out
);
    import prf_pkg::*;

    logic [63:0] lfsr_reg, lfsr_next;
    logic [63:0] seed_reg;
    logic [62:0] n_reg, x_reg, y_reg, c_reg;
    logic [63:0] acc_reg, add_reg;
    logic [62:0] mlt_reg;
    // shared restoring remainder/divide unit
    logic [63:0] a_reg, b_reg, r_reg, q_reg;
    logic [6:0]  bit_reg;
    logic [63:0] d_reg;

    logic [63:0] s1, s2, s3;
    logic [63:0] sum_acc, sum_add, rsh, rsub;
    logic [63:0] n64, z64;
    logic        ge;

    assign n64 = {1'b0, n_reg};

    always_comb
    begin
        s1 = lfsr_reg ^ (lfsr_reg << 13);
        s2 = s1 ^ (s1 >> 7);
        s3 = s2 ^ (s2 << 17);
        lfsr_next = (s3 == 64'd0) ? 64'd1 : s3;
        sum_acc = acc_reg + add_reg;
        if (sum_acc >= n64) sum_acc = sum_acc - n64;
        sum_add = add_reg + add_reg;
        if (sum_add >= n64) sum_add = sum_add - n64;
        z64 = (x_reg < y_reg) ? (n64 + {1'b0, x_reg} - {1'b0, y_reg})
                              : ({1'b0, x_reg} - {1'b0, y_reg});
        // one remainder bit per cycle, dividend a_reg MSB first
        rsh  = {r_reg[62:0], a_reg[bit_reg[5:0]]};
        ge   = (rsh >= b_reg);
        rsub = ge ? rsh - b_reg : rsh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= 64'd1;
            seed_reg <= 64'd1;
        end
        else if (seed_we)
        begin
            seed_reg <= seed_value;
            lfsr_reg <= (seed_value == 64'd0) ? 64'd1 : seed_value;
        end
        else if (cmd.op == OP_DRAW_INC || cmd.op == OP_DRAW_START)
            lfsr_reg <= lfsr_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD: n_reg <= composite;
            OP_DRAW_INC:
            begin
                // the increment r is drawn in 17..32 and reduced mod n through the shared unit
                a_reg   <= {60'd0, lfsr_next[3:0]} + 64'd17;
                b_reg   <= n64;
                r_reg   <= 64'd0;
                bit_reg <= 7'd63;
                d_reg   <= 64'd0;
            end
            OP_DRAW_START:
            begin
                a_reg   <= lfsr_next;
                b_reg   <= n64 - 64'd1;
                r_reg   <= 64'd0;
                bit_reg <= 7'd63;
            end
            OP_MUL_START:
            begin
                add_reg <= {1'b0, x_reg};
                mlt_reg <= x_reg;
                acc_reg <= {1'b0, c_reg};
            end
            OP_MUL_STEP:
            begin
                if (mlt_reg[0]) acc_reg <= sum_acc;
                add_reg <= sum_add;
                mlt_reg <= mlt_reg >> 1;
            end
            OP_MUL_DONE: x_reg <= acc_reg[62:0];
            OP_GCD_START:
            begin
                a_reg   <= z64;
                b_reg   <= n64;
                r_reg   <= 64'd0;
                bit_reg <= 7'd63;
            end
            OP_GCD_STEP:
            begin
                if (b_reg == 64'd0)
                    d_reg <= a_reg;
                else if (bit_reg == 7'd0)
                begin
                    // one Euclid step complete
                    a_reg   <= b_reg;
                    b_reg   <= rsub;
                    r_reg   <= 64'd0;
                    bit_reg <= 7'd63;
                end
                else
                begin
                    r_reg   <= rsub;
                    bit_reg <= bit_reg - 7'd1;
                end
            end
            OP_ANCHOR: y_reg <= x_reg;
            OP_DIV_START:
            begin
                a_reg   <= n64;
                b_reg   <= d_reg;
                r_reg   <= 64'd0;
                q_reg   <= 64'd0;
                bit_reg <= 7'd63;
            end
            OP_DIV_STEP:
            begin
                if (bit_reg[6] == 1'b0)
                begin
                    r_reg   <= rsub;
                    q_reg   <= {q_reg[62:0], ge};
                    bit_reg <= bit_reg - 7'd1;
                end
            end
            OP_NONE:
            begin
                // remainder passes used for the draws
                if (bit_reg[6] == 1'b0)
                begin
                    r_reg   <= rsub;
                    bit_reg <= bit_reg - 7'd1;
                end
            end
            default: ;
        endcase
        // capture draw remainders when finished
        if (cmd.op == OP_NONE && bit_reg == 7'd0)
        begin
            if (d_reg == 64'd0 && b_reg == n64)
                c_reg <= rsub[62:0];
            else
            begin
                x_reg <= rsub[62:0] + 63'd1;
                y_reg <= rsub[62:0] + 63'd1;
            end
        end
    end

    // d_reg is zero during both draw remainders; b_reg equal to n marks the increment draw
    always_comb
    begin
        status.mul_done   = (mlt_reg == 63'd0);
        status.gcd_done   = (b_reg == 64'd0);
        status.div_done   = bit_reg[6];
        status.rem_done   = bit_reg[6];
        status.gcd_is_one = (d_reg == 64'd1);
        status.gcd_found  = (d_reg > 64'd1) && (d_reg < n64);
    end

    always_comb
    begin
        if (q_reg < d_reg)
        begin
            small_out = q_reg[62:0];
            large_out = d_reg[62:0];
        end
        else
        begin
            small_out = d_reg[62:0];
            large_out = q_reg[62:0];
        end
    end

    assign seed_out = seed_reg;
endmodule

// File: rtl/prf_control.sv
// Controller: sequences rounds, steps, multiply, gcd and the final divide.
module prf_control (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                in_small,
    input  prf_pkg::dp_status_t status,
    input  logic                out_free,
    output prf_pkg::dp_cmd_t    cmd,
    output logic                busy,
    output logic                done,
    output logic [1:0]          result_kind
);
    import prf_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INC    = 4'd1;
    localparam logic [3:0] S_INCW   = 4'd2;
    localparam logic [3:0] S_START  = 4'd3;
    localparam logic [3:0] S_STARTW = 4'd4;
    localparam logic [3:0] S_MUL0   = 4'd5;
    localparam logic [3:0] S_MUL    = 4'd6;
    localparam logic [3:0] S_GCD0   = 4'd7;
    localparam logic [3:0] S_GCD    = 4'd8;
    localparam logic [3:0] S_EVAL   = 4'd9;
    localparam logic [3:0] S_DIV0   = 4'd10;
    localparam logic [3:0] S_DIV    = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    logic [3:0]  state_reg, state_next;
    logic [31:0] step_reg, step_next, total_reg, total_next;
    logic [15:0] round_reg, round_next;
    logic [1:0]  kind_reg, kind_next;
    logic [4:0]  exp_v;
    logic [31:0] lim_v;
    logic [16:0] e_sum;

    always_comb
    begin
        e_sum = {1'b0, round_reg} + 17'(BASE_ROUND_LOG);
        exp_v = (e_sum > 17'd31) ? 5'd31 : e_sum[4:0];
        lim_v = 32'd1 << exp_v;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        total_next = total_reg;
        round_next = round_reg;
        kind_next  = kind_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    cmd.op = OP_LOAD;
                    total_next = 32'd0;
                    round_next = 16'd0;
                    if (in_small)
                    begin
                        kind_next  = STATUS_INVALID;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_INC;
                end
            S_INC:    begin cmd.op = OP_DRAW_INC;   state_next = S_INCW;   end
            S_INCW:   if (status.rem_done) state_next = S_START;
            S_START:  begin cmd.op = OP_DRAW_START; state_next = S_STARTW; end
            S_STARTW:
                if (status.rem_done)
                begin
                    step_next  = 32'd1;
                    state_next = (lim_v > 32'd1) ? S_MUL0 : S_EVAL;
                end
            S_MUL0:
            begin
                cmd.op = OP_MUL_START;
                if (total_reg != 32'hFFFF_FFFF) total_next = total_reg + 32'd1;
                state_next = S_MUL;
            end
            S_MUL:
                if (status.mul_done)
                begin
                    cmd.op = OP_MUL_DONE;
                    state_next = S_GCD0;
                end
                else
                    cmd.op = OP_MUL_STEP;
            S_GCD0:   begin cmd.op = OP_GCD_START; state_next = S_GCD; end
            S_GCD:
            begin
                cmd.op = OP_GCD_STEP;
                if (status.gcd_done) state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (step_reg < lim_v && status.gcd_is_one)
                begin
                    if ((step_reg & (step_reg - 32'd1)) == 32'd0) cmd.op = OP_ANCHOR;
                    step_next = step_reg + 32'd1;
                    state_next = (step_reg + 32'd1 < lim_v) ? S_MUL0 : S_EVAL;
                end
                else
                begin
                    if (round_reg != 16'hFFFF) round_next = round_reg + 16'd1;
                    if (status.gcd_found)
                    begin
                        kind_next  = STATUS_FOUND;
                        state_next = S_DIV0;
                    end
                    else if ((round_next < 16'(MIN_ROUNDS)) ||
                             (total_reg < 32'(MIN_TOTAL_STEPS)))
                        state_next = S_INC;
                    else
                    begin
                        kind_next  = STATUS_NONE;
                        state_next = S_OUT;
                    end
                end
            end
            S_DIV0:   begin cmd.op = OP_DIV_START; state_next = S_DIV; end
            S_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (status.div_done) state_next = S_OUT;
            end
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 32'd0;
            total_reg <= 32'd0;
            round_reg <= 16'd0;
            kind_reg  <= STATUS_FOUND;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            total_reg <= total_next;
            round_reg <= round_next;
            kind_reg  <= kind_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = (state_reg == S_OUT) && out_free;
    assign result_kind = kind_reg;
endmodule
